// File: rtl/nlt_pkg.sv
package nlt_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 9;
  localparam int CFG_W   = 10;
  localparam int K_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_K_SCALED     = 2'd3;

  localparam logic [PIX_W-1:0] BIN_DARK  = 8'd0;
  localparam logic [PIX_W-1:0] BIN_LIGHT = 8'd255;

  typedef struct packed {
    logic rd;
    logic wr;
  } nlt_mem_ctrl_t;

endpackage

// File: rtl/niblack_local_threshold.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall  | mode, pixel_value, frame_start, query_column/row
// out     | output    | out_valid / out_stall| binary_value, result_column/row, not_ready
// cfg     | input     | cfg_wr_en            | cfg_index, cfg_wr_data
//
// A load steps through accept, read of the entry one row up, and write back.
// A query works out the window bounds, does five store reads, then runs the multiply
// and the one-bit-per-cycle square root unit.
// A query before a complete frame skips the math. One item is in flight at a time.
// The result sits in an output register; loads go on while it waits on out_stall.
// Reset is synchronous; the stores are not cleared and are valid once written.
module niblack_local_threshold #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [nlt_pkg::PIX_W-1:0]       in_pixel_value,
  input  logic                            in_frame_start,
  input  logic [nlt_pkg::COORD_W-1:0]     in_query_column,
  input  logic [nlt_pkg::COORD_W-1:0]     in_query_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nlt_pkg::PIX_W-1:0]       out_binary_value,
  output logic [nlt_pkg::COORD_W-1:0]     out_result_column,
  output logic [nlt_pkg::COORD_W-1:0]     out_result_row,
  output logic                            out_not_ready,
  input  logic                            cfg_wr_en,
  input  logic [nlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nlt_pkg::CFG_W-1:0]       cfg_wr_data
);
  import nlt_pkg::*;

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MA    = CW + RW;
  localparam int SUM_W = $clog2(64'd255 * MAX_WIDTH * MAX_HEIGHT + 64'd1);
  localparam int SQ_W  = $clog2(64'd65025 * MAX_WIDTH * MAX_HEIGHT + 64'd1);
  localparam int RS_W  = $clog2(64'd255 * MAX_WIDTH + 64'd1);
  localparam int RQ_W  = $clog2(64'd65025 * MAX_WIDTH + 64'd1);
  localparam int XW    = ((CW > COORD_W) ? CW : COORD_W) + 1;
  localparam int YW    = ((RW > COORD_W) ? RW : COORD_W) + 1;
  localparam int AW    = CW + RW + 2;

  localparam logic [2:0] CRN_BR  = 3'd0;
  localparam logic [2:0] CRN_BL  = 3'd1;
  localparam logic [2:0] CRN_TR  = 3'd2;
  localparam logic [2:0] CRN_TL  = 3'd3;
  localparam logic [2:0] CRN_PIX = 3'd4;
  localparam logic [2:0] CRN_END = 3'd5;

  typedef enum logic [2:0] {
    IDLE, LD_READ, LD_WRITE, Q_WIN, Q_READ, Q_MATH, Q_OUT
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0]      width_r;
  logic [CFG_W-1:0]      height_r;
  logic [7:0]            half_r;
  logic signed [K_W-1:0] k_r;

  logic [CW-1:0]   ld_col_r;
  logic [RW-1:0]   ld_row_r;
  logic [RS_W-1:0] rs_r;
  logic [RQ_W-1:0] rq_r;
  logic            complete_r;
  logic [PIX_W-1:0] pix_r;

  logic [CW-1:0]   qcol_r;
  logic [RW-1:0]   qrow_r;
  logic [CW-1:0]   x1_r, x2_r;
  logic [RW-1:0]   y1_r, y2_r;
  logic [CW:0]     dx_r;
  logic [RW:0]     dy_r;
  logic            hasx_r, hasy_r;
  logic [2:0]      cnt_r;
  logic [AW-1:0]   area_r;
  logic [SUM_W-1:0] s_r;
  logic [SQ_W-1:0]  q_r;
  logic [PIX_W-1:0] qpix_r;
  logic            start_r;
  logic [PIX_W-1:0] res_bin_r;
  logic             res_nr_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_bin_r;
  logic [COORD_W-1:0] out_col_r, out_row_r;
  logic             out_nr_r;

  logic [CW:0] w_eff;
  logic [RW:0] h_eff;
  logic [XW-1:0] wl, qc_in, qc, rx, x1_c, x2_t, x2_c;
  logic [YW-1:0] hl, qr_in, qr, ry, y1_c, y2_t, y2_c;
  logic [XW-1:0] qc_sat;
  logic [YW-1:0] qr_sat;

  nlt_mem_ctrl_t    mem_ctrl;
  logic [MA-1:0]    raddr, waddr;
  logic [PIX_W-1:0] rd_pix;
  logic [SUM_W-1:0] rd_sum, wr_sum;
  logic [SQ_W-1:0]  rd_sq, wr_sq;
  logic [RS_W-1:0]  rs_new;
  logic [RQ_W-1:0]  rq_new;

  logic math_done, math_light;
  logic in_acc;

  always_comb begin
    if (width_r == '0) w_eff = (CW+1)'(1);
    else if (width_r > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(width_r);
    if (height_r == '0) h_eff = (RW+1)'(1);
    else if (height_r > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
    else h_eff = (RW+1)'(height_r);
  end

  always_comb begin
    wl     = XW'(w_eff) - XW'(1);
    hl     = YW'(h_eff) - YW'(1);
    qc_in  = XW'(in_query_column);
    qr_in  = YW'(in_query_row);
    qc_sat = (qc_in > wl) ? wl : qc_in;
    qr_sat = (qr_in > hl) ? hl : qr_in;
    qc     = XW'(qcol_r);
    qr     = YW'(qrow_r);
    rx     = XW'(half_r);
    ry     = YW'(half_r);
    x1_c   = (qc > rx) ? qc - rx : '0;
    y1_c   = (qr > ry) ? qr - ry : '0;
    x2_t   = qc + rx;
    y2_t   = qr + ry;
    x2_c   = (x2_t > wl) ? wl : x2_t;
    y2_c   = (y2_t > hl) ? hl : y2_t;
  end

  assign in_stall = (state_r != IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Store addressing
  always_comb begin
    mem_ctrl.rd = (state_r == LD_READ) || (state_r == Q_READ && cnt_r < CRN_END);
    mem_ctrl.wr = (state_r == LD_WRITE);
    waddr = {ld_row_r, ld_col_r};
    raddr = {ld_row_r - RW'(1), ld_col_r};
    if (state_r == Q_READ) begin
      case (cnt_r)
        CRN_BR:  raddr = {y2_r, x2_r};
        CRN_BL:  raddr = {y2_r, x1_r - CW'(1)};
        CRN_TR:  raddr = {y1_r - RW'(1), x2_r};
        CRN_TL:  raddr = {y1_r - RW'(1), x1_r - CW'(1)};
        default: raddr = {qrow_r, qcol_r};
      endcase
    end
  end

  always_comb begin
    rs_new = rs_r + RS_W'(pix_r);
    rq_new = rq_r + RQ_W'(pix_r) * RQ_W'(pix_r);
    wr_sum = SUM_W'(rs_new) + ((ld_row_r == '0) ? '0 : rd_sum);
    wr_sq  = SQ_W'(rq_new) + ((ld_row_r == '0) ? '0 : rd_sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      width_r     <= CFG_W'(512);
      height_r    <= CFG_W'(512);
      half_r      <= 8'd7;
      k_r         <= -K_W'(51);
      ld_col_r    <= '0;
      ld_row_r    <= '0;
      rs_r        <= '0;
      rq_r        <= '0;
      complete_r  <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (state_r == Q_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        IDLE: begin
          if (in_acc) begin
            if (in_mode == MODE_LOAD) begin
              pix_r <= in_pixel_value;
              if (in_frame_start || complete_r) begin
                ld_col_r   <= '0;
                ld_row_r   <= '0;
                rs_r       <= '0;
                rq_r       <= '0;
                complete_r <= 1'b0;
              end
              state_r <= LD_READ;
            end else begin
              qcol_r    <= qc_sat[CW-1:0];
              qrow_r    <= qr_sat[RW-1:0];
              res_nr_r  <= !complete_r;
              res_bin_r <= BIN_DARK;
              state_r   <= complete_r ? Q_WIN : Q_OUT;
            end
          end
        end
        LD_READ: state_r <= LD_WRITE;
        LD_WRITE: begin
          if ({1'b0, ld_col_r} + (CW+1)'(1) >= w_eff) begin
            ld_col_r <= '0;
            rs_r     <= '0;
            rq_r     <= '0;
            if ({1'b0, ld_row_r} + (RW+1)'(1) >= h_eff) begin
              ld_row_r   <= '0;
              complete_r <= 1'b1;
            end else begin
              ld_row_r <= ld_row_r + RW'(1);
            end
          end else begin
            ld_col_r <= ld_col_r + CW'(1);
            rs_r     <= rs_new;
            rq_r     <= rq_new;
          end
          state_r <= IDLE;
        end
        Q_WIN: begin
          x1_r   <= x1_c[CW-1:0];
          x2_r   <= x2_c[CW-1:0];
          y1_r   <= y1_c[RW-1:0];
          y2_r   <= y2_c[RW-1:0];
          dx_r   <= (CW+1)'(x2_c - x1_c + XW'(1));
          dy_r   <= (RW+1)'(y2_c - y1_c + YW'(1));
          hasx_r <= (x1_c != '0);
          hasy_r <= (y1_c != '0);
          cnt_r  <= CRN_BR;
          state_r <= Q_READ;
        end
        Q_READ: begin
          area_r <= AW'(dx_r) * AW'(dy_r);
          // data of the read issued last cycle
          case (cnt_r - 3'd1)
            CRN_BR: begin
              s_r <= rd_sum;
              q_r <= rd_sq;
            end
            CRN_BL: if (hasx_r) begin
              s_r <= s_r - rd_sum;
              q_r <= q_r - rd_sq;
            end
            CRN_TR: if (hasy_r) begin
              s_r <= s_r - rd_sum;
              q_r <= q_r - rd_sq;
            end
            CRN_TL: if (hasx_r && hasy_r) begin
              s_r <= s_r + rd_sum;
              q_r <= q_r + rd_sq;
            end
            CRN_PIX: qpix_r <= rd_pix;
            default: ;
          endcase
          if (cnt_r == CRN_END) begin
            start_r <= 1'b1;
            state_r <= Q_MATH;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        Q_MATH: begin
          if (math_done) begin
            res_bin_r <= math_light ? BIN_LIGHT : BIN_DARK;
            state_r   <= Q_OUT;
          end
        end
        Q_OUT: begin
          // hold the result until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_bin_r   <= res_bin_r;
            out_nr_r    <= res_nr_r;
            out_col_r   <= COORD_W'(qcol_r);
            out_row_r   <= COORD_W'(qrow_r);
            state_r     <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
            if (cfg_index == REG_IMAGE_WIDTH) width_r <= cfg_wr_data;
            else height_r <= cfg_wr_data;
            ld_col_r   <= '0;
            ld_row_r   <= '0;
            rs_r       <= '0;
            rq_r       <= '0;
            complete_r <= 1'b0;
          end
          REG_HALF_WINDOW: half_r <= cfg_wr_data[7:0];
          REG_K_SCALED:    k_r    <= $signed(cfg_wr_data[K_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  nlt_store #(.ADDR_W(MA), .SUM_W(SUM_W), .SQ_W(SQ_W)) u_store (
    .clk    (clk),
    .ctrl   (mem_ctrl),
    .raddr  (raddr),
    .waddr  (waddr),
    .wr_pix (pix_r),
    .wr_sum (wr_sum),
    .wr_sq  (wr_sq),
    .rd_pix (rd_pix),
    .rd_sum (rd_sum),
    .rd_sq  (rd_sq)
  );

  nlt_math #(.AW(AW), .SUM_W(SUM_W), .SQ_W(SQ_W)) u_math (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .area    (area_r),
    .win_sum (s_r),
    .win_sq  (q_r),
    .pix     (qpix_r),
    .k       (k_r),
    .done    (math_done),
    .light   (math_light)
  );

  assign out_valid         = out_valid_r;
  assign out_binary_value  = out_bin_r;
  assign out_result_column = out_col_r;
  assign out_result_row    = out_row_r;
  assign out_not_ready     = out_nr_r;

`ifndef SYNTHESIS
  a_nr_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_nr_r |-> out_bin_r == BIN_DARK)
    else $error("not-ready result with nonzero value");

  a_bin_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_bin_r == BIN_DARK || out_bin_r == BIN_LIGHT))
    else $error("binary value neither dark nor light");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_mode == MODE_LOAD && !out_valid_r |=> !out_valid_r)
    else $error("load beat produced a result");

  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctrl.rd && mem_ctrl.wr))
    else $error("store read and write in one cycle");

  a_math_done: assert property (@(posedge clk) disable iff (!rst_n)
    math_done |-> state_r == Q_MATH)
    else $error("math result outside query step");
`endif

endmodule

// File: rtl/nlt_store.sv
module nlt_store #(
  parameter int ADDR_W = 18,
  parameter int SUM_W  = 26,
  parameter int SQ_W   = 34
) (
  input  logic                       clk,
  input  nlt_pkg::nlt_mem_ctrl_t     ctrl,
  input  logic [ADDR_W-1:0]          raddr,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [nlt_pkg::PIX_W-1:0]  wr_pix,
  input  logic [SUM_W-1:0]           wr_sum,
  input  logic [SQ_W-1:0]            wr_sq,
  output logic [nlt_pkg::PIX_W-1:0]  rd_pix,
  output logic [SUM_W-1:0]           rd_sum,
  output logic [SQ_W-1:0]            rd_sq
);
  import nlt_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [PIX_W-1:0] pix_mem [DEPTH];
  logic [SUM_W-1:0] sum_mem [DEPTH];
  logic [SQ_W-1:0]  sq_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      pix_mem[waddr] <= wr_pix;
      sum_mem[waddr] <= wr_sum;
      sq_mem[waddr]  <= wr_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rd_pix <= pix_mem[raddr];
      rd_sum <= sum_mem[raddr];
      rd_sq  <= sq_mem[raddr];
    end
  end

endmodule

// File: rtl/nlt_math.sv
module nlt_math #(
  parameter int AW    = 20,
  parameter int SUM_W = 26,
  parameter int SQ_W  = 34
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [AW-1:0]             area,
  input  logic [SUM_W-1:0]          win_sum,
  input  logic [SQ_W-1:0]           win_sq,
  input  logic [nlt_pkg::PIX_W-1:0] pix,
  input  logic signed [nlt_pkg::K_W-1:0] k,
  output logic                      done,
  output logic                      light
);
  import nlt_pkg::*;

  localparam int QL    = (SQ_W + 1) / 2;
  localparam int QHW   = SQ_W - QL;
  localparam int AQ_W  = AW + SQ_W;
  localparam int SS_W  = 2 * SUM_W;
  localparam int VW    = (AQ_W > SS_W) ? AQ_W : SS_W;
  localparam int VE    = VW + (VW % 2);
  localparam int RTW   = VE / 2;
  localparam int RMW   = RTW + 4;
  localparam int LHW   = AW + PIX_W;
  localparam int KRW   = RTW + K_W + 1;
  localparam int M1    = (KRW > SUM_W + 8) ? KRW : SUM_W + 8;
  localparam int CPW   = ((M1 > LHW + 8) ? M1 : LHW + 8) + 2;
  localparam int CNTW  = $clog2(RTW + 1);

  typedef enum logic [2:0] {
    M_IDLE, M_AQL, M_AQH, M_SUM, M_DIFF, M_ROOT, M_KMUL, M_CMP
  } mstate_t;

  mstate_t state_r;

  logic [AW-1:0]        a_r;
  logic [SUM_W-1:0]     s_r;
  logic [SQ_W-1:0]      q_r;
  logic [PIX_W-1:0]     pix_r;
  logic signed [K_W-1:0] k_r;
  logic [AW+QL-1:0]     p_lo_r;
  logic [AW+QHW-1:0]    p_hi_r;
  logic [SS_W-1:0]      ss_r;
  logic [AQ_W-1:0]      aq_r;
  logic [LHW-1:0]       lhs_r;
  logic [VE-1:0]        vsh_r;
  logic [RMW-1:0]       rem_r;
  logic [RTW-1:0]       root_r;
  logic [CNTW-1:0]      cnt_r;
  logic signed [KRW-1:0] kr_r;
  logic                 done_r;
  logic                 light_r;

  logic [RMW-1:0] rem_t;
  logic [RMW-1:0] trial;
  logic [VW-1:0]  aq_ext;
  logic [VW-1:0]  ss_ext;
  logic signed [CPW-1:0] lhs_s;
  logic signed [CPW-1:0] rhs_s;

  always_comb begin
    rem_t  = {rem_r[RMW-3:0], vsh_r[VE-1 -: 2]};
    trial  = RMW'({root_r, 2'b01});
    aq_ext = VW'(aq_r);
    ss_ext = VW'(ss_r);
    lhs_s  = $signed(CPW'({lhs_r, 8'b0}));
    rhs_s  = $signed(CPW'({s_r, 8'b0}))
           + $signed({{(CPW-KRW){kr_r[KRW-1]}}, kr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      light_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            a_r     <= area;
            s_r     <= win_sum;
            q_r     <= win_sq;
            pix_r   <= pix;
            k_r     <= k;
            state_r <= M_AQL;
          end
        end
        M_AQL: begin
          p_lo_r  <= a_r * q_r[QL-1:0];
          lhs_r   <= a_r * pix_r;
          state_r <= M_AQH;
        end
        M_AQH: begin
          p_hi_r  <= a_r * q_r[SQ_W-1:QL];
          ss_r    <= s_r * s_r;
          state_r <= M_SUM;
        end
        M_SUM: begin
          aq_r    <= AQ_W'(p_lo_r) + (AQ_W'(p_hi_r) << QL);
          state_r <= M_DIFF;
        end
        M_DIFF: begin
          // floor the variance term at zero
          vsh_r   <= (aq_ext > ss_ext) ? VE'(aq_ext - ss_ext) : '0;
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= M_ROOT;
        end
        M_ROOT: begin
          if (rem_t >= trial) begin
            rem_r  <= rem_t - trial;
            root_r <= {root_r[RTW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_t;
            root_r <= {root_r[RTW-2:0], 1'b0};
          end
          vsh_r <= vsh_r << 2;
          cnt_r <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(RTW - 1)) state_r <= M_KMUL;
        end
        M_KMUL: begin
          kr_r    <= k_r * $signed({1'b0, root_r});
          state_r <= M_CMP;
        end
        M_CMP: begin
          light_r <= !(lhs_s < rhs_s);
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign light = light_r;

endmodule
